FILE: rtl/nlms_pkg.sv
`default_nettype none
package nlms_pkg;

    localparam int TAPS = 128;
    localparam int ADDR_W = $clog2(TAPS);
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int STEP_W = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd13107;
    localparam int ACC_W = 64;
    localparam int POW_W = 2 * SAMPLE_W + ADDR_W + 1;
    localparam int NUM_W = 64;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCUM,
        ST_ERROR,
        ST_DIVIDE,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/nlms_ram.sv
`default_nettype none
module nlms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/nlms_noise_canceller_top.sv
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   ref_sample[15:0], mic_sample[31:16]        mic_present
// m_axis    out  played_sample[15:0], error_sample[31:16]   -
// cfg       in   step_size[15:0] on cfg_wdata when cfg_we   -
// After reset a clearing pass zeroes both memories; no request is taken.
// One request takes one pass over the memories for the dot product, a 64-step restoring
// divide and one pass for the weight update.
// The delay line is a circular buffer; the newest sample overwrites the oldest entry.
// The result waits in an output register; s_axis_tready stays low until it is taken.
`default_nettype none
module nlms_noise_canceller_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // ref_sample, mic_sample
    input  wire logic        s_axis_tuser,   // mic_present
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // played_sample, error_sample
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    localparam int AW = nlms_pkg::ADDR_W;
    localparam int SW = nlms_pkg::SAMPLE_W;
    localparam int WW = nlms_pkg::WEIGHT_W;
    localparam int NW = nlms_pkg::NUM_W;

    nlms_pkg::state_t state_reg, state_next;

    logic [AW:0]                 cnt_reg, cnt_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [nlms_pkg::STEP_W-1:0] step_reg;
    logic signed [SW-1:0]        ref_reg, mic_reg;
    logic signed [nlms_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [nlms_pkg::POW_W-1:0]  pow_reg, pow_next;
    logic signed [SW-1:0]        err_out_reg, err_out_next;
    logic                        neg_reg, neg_next;
    logic [NW-1:0]               quo_reg, quo_next;
    logic [NW:0]                 rem_reg, rem_next;
    logic [nlms_pkg::CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic signed [NW-1:0]        g_reg, g_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;

    logic          hist_we, wt_we;
    logic [AW-1:0] hist_waddr, wt_waddr, rd_addr, wt_raddr;
    logic [SW-1:0] hist_wdata, hist_rdata;
    logic [WW-1:0] wt_wdata, wt_rdata;

    nlms_ram #(.WIDTH(SW), .DEPTH(nlms_pkg::TAPS)) u_hist (
        .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
        .raddr(rd_addr), .rdata(hist_rdata)
    );
    nlms_ram #(.WIDTH(WW), .DEPTH(nlms_pkg::TAPS)) u_wt (
        .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );

    logic signed [SW-1:0]   u_s;
    logic signed [WW-1:0]   w_s;
    logic signed [WW+SW-1:0] prod;
    logic signed [2*SW-1:0] sq;
    logic signed [nlms_pkg::ACC_W-1:0] ef;
    logic signed [nlms_pkg::ACC_W-1:0] e_full;
    logic signed [nlms_pkg::ACC_W-1:0] num_s;
    logic [NW-1:0]          num_mag;
    logic [NW:0]            rem_try;
    logic signed [NW+SW-1:0] gu;
    logic signed [NW+SW:0]  nw_sum;
    logic signed [WW-1:0]   nw_sat;

    always_comb
    begin
        u_s    = signed'(hist_rdata);
        w_s    = signed'(wt_rdata);
        prod   = w_s * u_s;
        sq     = u_s * u_s;
        ef     = (nlms_pkg::ACC_W'(mic_reg) <<< 28) - acc_reg;
        e_full = ef >>> 28;
        if (ef < 0 && ef[27:0] != 28'd0)
        begin
            e_full = e_full + 1;
        end
        num_s   = e_full * signed'({1'b0, step_reg}) * 64'sd4096;
        num_mag = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
        rem_try = {rem_reg[NW-1:0], quo_reg[NW-1]};
        gu      = g_reg * u_s;
        nw_sum  = (NW+SW+1)'(w_s) + (NW+SW+1)'(gu);
        if (nw_sum > (NW+SW+1)'(64'sh7FFFFFFF))
        begin
            nw_sat = 32'sh7FFFFFFF;
        end
        else if (nw_sum < -(NW+SW+1)'(64'sh80000000))
        begin
            nw_sat = 32'sh80000000;
        end
        else
        begin
            nw_sat = nw_sum[WW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nlms_pkg::ST_CLEAR:
            begin
                if (cnt_reg == (AW+1)'(nlms_pkg::TAPS - 1))
                begin
                    state_next = nlms_pkg::ST_IDLE;
                end
            end
            nlms_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = nlms_pkg::ST_ACCUM;
                end
            end
            nlms_pkg::ST_ACCUM:
            begin
                if (rd_valid_reg && cnt_reg == (AW+1)'(nlms_pkg::TAPS))
                begin
                    state_next = nlms_pkg::ST_ERROR;
                end
            end
            nlms_pkg::ST_ERROR:  state_next = nlms_pkg::ST_DIVIDE;
            nlms_pkg::ST_DIVIDE:
            begin
                if (dcnt_reg == nlms_pkg::CNT_W'(NW))
                begin
                    state_next = nlms_pkg::ST_UPDATE;
                end
            end
            nlms_pkg::ST_UPDATE:
            begin
                if (rd_valid_reg && cnt_reg == (AW+1)'(nlms_pkg::TAPS))
                begin
                    state_next = nlms_pkg::ST_OUTPUT;
                end
            end
            nlms_pkg::ST_OUTPUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = nlms_pkg::ST_IDLE;
                end
            end
            default: state_next = nlms_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        acc_next      = acc_reg;
        pow_next      = pow_reg;
        err_out_next  = err_out_reg;
        neg_next      = neg_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        g_next        = g_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        hist_we       = 1'b0;
        wt_we         = 1'b0;
        hist_waddr    = cnt_reg[AW-1:0];
        wt_waddr      = rd_idx_reg;
        hist_wdata    = '0;
        wt_wdata      = '0;
        rd_addr       = cnt_reg[AW-1:0];
        wt_raddr      = cnt_reg[AW-1:0];
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            nlms_pkg::ST_CLEAR:
            begin
                hist_we  = 1'b1;
                wt_we    = 1'b1;
                wt_waddr = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(nlms_pkg::TAPS - 1))
                begin
                    cnt_next = '0;
                end
            end
            nlms_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                hist_waddr    = head_reg - 1'b1;
                hist_wdata    = s_axis_tdata[SW-1:0];
                if (s_axis_tvalid)
                begin
                    hist_we   = 1'b1;
                    head_next = head_reg - 1'b1;
                    cnt_next  = '0;
                    acc_next  = '0;
                    pow_next  = nlms_pkg::POW_W'(1);
                end
            end
            nlms_pkg::ST_ACCUM, nlms_pkg::ST_UPDATE:
            begin
                rd_addr = head_reg + cnt_reg[AW-1:0];
                if (cnt_reg != (AW+1)'(nlms_pkg::TAPS))
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (state_reg == nlms_pkg::ST_ACCUM)
                    begin
                        acc_next = acc_reg + nlms_pkg::ACC_W'(prod);
                        pow_next = pow_reg + nlms_pkg::POW_W'(unsigned'(sq));
                    end
                    else
                    begin
                        wt_we    = 1'b1;
                        wt_wdata = nw_sat;
                    end
                end
            end
            nlms_pkg::ST_ERROR:
            begin
                if (e_full > 64'sd32767)
                begin
                    err_out_next = 16'sh7FFF;
                end
                else if (e_full < -64'sd32768)
                begin
                    err_out_next = 16'sh8000;
                end
                else
                begin
                    err_out_next = e_full[SW-1:0];
                end
                neg_next  = num_s[NW-1];
                quo_next  = num_mag;
                rem_next  = '0;
                dcnt_next = '0;
            end
            nlms_pkg::ST_DIVIDE:
            begin
                if (dcnt_reg != nlms_pkg::CNT_W'(NW))
                begin
                    dcnt_next = dcnt_reg + 1'b1;
                    if (rem_try >= (NW+1)'(pow_reg))
                    begin
                        rem_next = rem_try - (NW+1)'(pow_reg);
                        quo_next = {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_try;
                        quo_next = {quo_reg[NW-2:0], 1'b0};
                    end
                end
                else
                begin
                    g_next   = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);
                    cnt_next = '0;
                end
            end
            nlms_pkg::ST_OUTPUT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nlms_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            head_reg     <= '0;
            step_reg     <= nlms_pkg::STEP_RESET;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        pow_reg     <= pow_next;
        err_out_reg <= err_out_next;
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        g_reg       <= g_next;
        rd_idx_reg  <= rd_idx_next;
        if (state_reg == nlms_pkg::ST_IDLE && s_axis_tvalid)
        begin
            ref_reg <= s_axis_tdata[SW-1:0];
            mic_reg <= s_axis_tuser ? s_axis_tdata[2*SW-1:SW] : '0;
        end
    end

    assign m_axis_tdata = {err_out_reg, ref_reg};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_wr_pass: assert property (@(posedge clk) disable iff (!rst_n)
        wt_we |-> (state_reg == nlms_pkg::ST_UPDATE || state_reg == nlms_pkg::ST_CLEAR))
        else $error("weight write outside update");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nlms_pkg::ST_DIVIDE |-> dcnt_reg <= nlms_pkg::CNT_W'(NW))
        else $error("divider overrun");

endmodule
`default_nettype wire
